FILE: rtl/trs_pkg.sv
// Shared constants, entry layout and controller/datapath interface types for the tempo ramp stepper.
package trs_pkg;

    localparam int SCORE_COUNT = 4;
    localparam int SEQ_COUNT   = 16;
    localparam int ENTRY_COUNT = SCORE_COUNT * SEQ_COUNT;
    localparam int ENTRY_W     = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

    localparam int TEMPO_W = 15;
    localparam int STEP_W  = 16;
    localparam int CNT_W   = 32;
    localparam int RES_W   = 15;
    localparam int RATE_W  = 28;
    localparam int FLAG_W  = 2;
    localparam int FR_W    = 8;

    // res * tempo, then times ten
    localparam int PROD_W    = RES_W + TEMPO_W;
    localparam int DVD_W     = PROD_W + 4;
    localparam int DVS_W     = 16;
    localparam int DIV_CNT_W = $clog2(DVD_W);

    localparam int FRAME_SECS = 60;
    localparam logic [FR_W-1:0] FRAME_RATE_RST = FR_W'(60);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic [TEMPO_W-1:0]       tempo;
        logic [TEMPO_W-1:0]       target;
        logic signed [STEP_W-1:0] step;
        logic [CNT_W-1:0]         cnt;
        logic [RES_W-1:0]         res;
        logic [RATE_W-1:0]        rate;
        logic [FLAG_W-1:0]        flags;
    } t_entry;

    typedef struct packed {
        logic accept;
        logic fetch;
        logic mod_start;
        logic step;
        logic mul;
        logic rate_start;
        logic rate_latch;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic in_oor;
        logic in_tick;
        logic step_pos;
        logic div_done;
        logic rem_zero;
        logic out_free;
    } t_stat;

endpackage

FILE: rtl/tempo_ramp_stepper_top.sv
// Top level of the tempo ramp stepper: controller plus datapath.
// Handles one word at a time over a 64-entry sequence table. A load multiplies and then
// divides for the tick rate; a tick with zero or negative step fetches, steps the tempo,
// multiplies and divides; a tick with positive step first takes the counter modulo the
// step and, only when the counter is a multiple of the step, goes on to step the tempo
// and divide for the rate. Both divisions use the shared restoring divider. A new word is
// accepted as soon as the previous result sits in the output register, even if it has
// not yet been taken. The frame rate register resets to 60; the user must write it
// through i_cfg_we/i_cfg_data only while idle, and the block itself does not enforce it.
module tempo_ramp_stepper_top
    import trs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [FR_W-1:0]          i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_op,
    input  logic [1:0]               i_score_index,
    input  logic [3:0]               i_seq_index,
    input  logic [TEMPO_W-1:0]       i_load_tempo,
    input  logic [TEMPO_W-1:0]       i_load_target,
    input  logic signed [STEP_W-1:0] i_load_step,
    input  logic signed [CNT_W-1:0]  i_load_ticks,
    input  logic [RES_W-1:0]         i_load_resolution,
    input  logic [FLAG_W-1:0]        i_load_flags,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [TEMPO_W-1:0]       o_tempo,
    output logic [RATE_W-1:0]        o_tick_rate,
    output logic [FLAG_W-1:0]        o_ramp_flags,
    output logic signed [CNT_W-1:0]  o_ticks_left
);

    t_cmd  cmd;
    t_stat stat;

    trs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_ready (o_ready),
        .o_cmd   (cmd)
    );

    trs_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_op              (i_op),
        .i_score_index     (i_score_index),
        .i_seq_index       (i_seq_index),
        .i_load_tempo      (i_load_tempo),
        .i_load_target     (i_load_target),
        .i_load_step       (i_load_step),
        .i_load_ticks      (i_load_ticks),
        .i_load_resolution (i_load_resolution),
        .i_load_flags      (i_load_flags),
        .i_ready           (i_ready),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_valid           (o_valid),
        .o_tempo           (o_tempo),
        .o_tick_rate       (o_tick_rate),
        .o_ramp_flags      (o_ramp_flags),
        .o_ticks_left      (o_ticks_left)
    );

endmodule

FILE: rtl/trs_div.sv
// Restoring divider, one quotient bit per cycle, shared by the step modulo and the rate divide.
module trs_div
    import trs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient,
    output logic [DVS_W-1:0] o_remainder
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_count;
    logic [DVD_W-1:0]     r_quo;
    logic [DVS_W-1:0]     r_rem;
    logic [DVS_W-1:0]     r_dvs;

    logic [DVS_W:0] shifted;
    logic [DVS_W:0] diff;

    assign shifted = {r_rem, r_quo[DVD_W-1]};
    assign diff    = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= DIV_CNT_W'(DVD_W - 1);
            end else if (r_busy) begin
                r_count <= r_count - 1'b1;
                if (r_count == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            // subtract when the partial remainder covers the divisor
            if (!diff[DVS_W]) begin
                r_rem <= diff[DVS_W-1:0];
                r_quo <= {r_quo[DVD_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[DVS_W-1:0];
                r_quo <= {r_quo[DVD_W-2:0], 1'b0};
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

FILE: rtl/trs_datapath.sv
// Entry memory, working registers, tempo arithmetic, rate multiply/divide and output register.
module trs_datapath
    import trs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [FR_W-1:0]          i_cfg_data,
    input  logic                     i_op,
    input  logic [1:0]               i_score_index,
    input  logic [3:0]               i_seq_index,
    input  logic [TEMPO_W-1:0]       i_load_tempo,
    input  logic [TEMPO_W-1:0]       i_load_target,
    input  logic signed [STEP_W-1:0] i_load_step,
    input  logic signed [CNT_W-1:0]  i_load_ticks,
    input  logic [RES_W-1:0]         i_load_resolution,
    input  logic [FLAG_W-1:0]        i_load_flags,
    input  logic                     i_ready,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    output logic                     o_valid,
    output logic [TEMPO_W-1:0]       o_tempo,
    output logic [RATE_W-1:0]        o_tick_rate,
    output logic [FLAG_W-1:0]        o_ramp_flags,
    output logic signed [CNT_W-1:0]  o_ticks_left
);

    t_entry r_mem [ENTRY_COUNT];
    t_entry r_rd_data;
    logic [ENTRY_COUNT-1:0] r_flag_vld;

    logic [FR_W-1:0]          r_frame_rate;
    logic                     r_valid;
    logic                     r_op;
    logic                     r_oor;
    logic [ENTRY_W-1:0]       r_addr;
    logic [TEMPO_W-1:0]       r_tempo;
    logic [TEMPO_W-1:0]       r_target;
    logic signed [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]         r_cnt;
    logic [RES_W-1:0]         r_res;
    logic [RATE_W-1:0]        r_rate;
    logic [FLAG_W-1:0]        r_flags;
    logic [PROD_W-1:0]        r_prod;

    logic [TEMPO_W-1:0]       r_out_tempo;
    logic [RATE_W-1:0]        r_out_rate;
    logic [FLAG_W-1:0]        r_out_flags;
    logic [CNT_W-1:0]         r_out_cnt;

    logic [ENTRY_W-1:0] in_addr;
    logic               in_oor;
    logic               step_pos;
    logic [CNT_W-1:0]   cnt_abs;
    logic [FR_W-1:0]    fr_eff;
    logic [DVS_W-1:0]   rate_dvs;
    logic [DVD_W-1:0]   prod10;
    logic               div_start;
    logic [DVD_W-1:0]   div_dvd;
    logic [DVS_W-1:0]   div_dvs;
    logic               div_done;
    logic [DVD_W-1:0]   div_quo;
    logic [DVS_W-1:0]   div_rem;
    logic [FLAG_W-1:0]  n_flags;
    t_entry             wr_entry;

    logic signed [17:0] t_s;
    logic signed [17:0] g_s;
    logic signed [17:0] s_s;
    logic signed [17:0] n_tempo;

    assign in_addr = ENTRY_W'(i_score_index) * ENTRY_W'(SEQ_COUNT) + ENTRY_W'(i_seq_index);
    assign in_oor  = (int'(i_score_index) >= SCORE_COUNT) || (int'(i_seq_index) >= SEQ_COUNT);

    assign step_pos = !r_step[STEP_W-1] && (r_step != '0);
    assign cnt_abs  = r_cnt[CNT_W-1] ? (~r_cnt + 1'b1) : r_cnt;
    assign fr_eff   = (r_frame_rate == '0) ? FR_W'(1) : r_frame_rate;
    assign rate_dvs = DVS_W'(fr_eff) * DVS_W'(FRAME_SECS);
    assign prod10   = (DVD_W'(r_prod) << 3) + (DVD_W'(r_prod) << 1);

    assign div_start = i_cmd.mod_start || i_cmd.rate_start;
    assign div_dvd   = i_cmd.mod_start ? DVD_W'(cnt_abs) : prod10;
    assign div_dvs   = i_cmd.mod_start ? DVS_W'(r_step) : rate_dvs;

    trs_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dvd),
        .i_divisor   (div_dvs),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // move the tempo one unit, or by the step magnitude clamped at the target
    always_comb begin
        t_s     = $signed({3'b000, r_tempo});
        g_s     = $signed({3'b000, r_target});
        s_s     = {{2{r_step[STEP_W-1]}}, r_step};
        n_tempo = t_s;
        if (step_pos) begin
            if (t_s > g_s) begin
                n_tempo = t_s - 18'sd1;
            end else if (t_s < g_s) begin
                n_tempo = t_s + 18'sd1;
            end
        end else begin
            if (t_s > g_s) begin
                n_tempo = t_s + s_s;
                if (n_tempo < g_s) begin
                    n_tempo = g_s;
                end
            end else if (t_s < g_s) begin
                n_tempo = t_s - s_s;
                if (n_tempo > g_s) begin
                    n_tempo = g_s;
                end
            end
        end
    end

    always_comb begin
        n_flags = r_flags;
        if (r_op == OP_TICK && (r_cnt == '0 || r_tempo == r_target)) begin
            n_flags = '0;
        end
    end

    always_comb begin
        wr_entry.tempo  = r_tempo;
        wr_entry.target = r_target;
        wr_entry.step   = r_step;
        wr_entry.cnt    = r_cnt;
        wr_entry.res    = r_res;
        wr_entry.rate   = r_rate;
        wr_entry.flags  = n_flags;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && !r_oor) begin
            r_mem[r_addr] <= wr_entry;
        end
        r_rd_data <= r_mem[in_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_rate <= FRAME_RATE_RST;
            r_flag_vld   <= '0;
            r_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_frame_rate <= i_cfg_data;
            end
            if (i_cmd.commit && !r_oor) begin
                r_flag_vld[r_addr] <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op     <= i_op;
            r_oor    <= in_oor;
            r_addr   <= in_addr;
            r_tempo  <= i_load_tempo;
            r_target <= i_load_target;
            r_step   <= i_load_step;
            r_cnt    <= i_load_ticks;
            r_res    <= i_load_resolution;
            r_flags  <= i_load_flags;
        end
        if (i_cmd.fetch) begin
            r_tempo  <= r_rd_data.tempo;
            r_target <= r_rd_data.target;
            r_step   <= r_rd_data.step;
            r_cnt    <= r_rd_data.cnt - 1'b1;
            r_res    <= r_rd_data.res;
            r_rate   <= r_rd_data.rate;
            r_flags  <= r_flag_vld[r_addr] ? r_rd_data.flags : '0;
        end
        if (i_cmd.step) begin
            r_tempo <= n_tempo[TEMPO_W-1:0];
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_res) * PROD_W'(r_tempo);
        end
        if (i_cmd.rate_latch) begin
            r_rate <= (div_quo == '0) ? RATE_W'(1) : div_quo[RATE_W-1:0];
        end
        if (i_cmd.commit) begin
            // an address outside the table answers with an all-zero word
            r_out_tempo <= r_oor ? '0 : r_tempo;
            r_out_rate  <= r_oor ? '0 : r_rate;
            r_out_flags <= r_oor ? '0 : n_flags;
            r_out_cnt   <= r_oor ? '0 : r_cnt;
        end
    end

    assign o_stat.in_oor   = in_oor;
    assign o_stat.in_tick  = (i_op == OP_TICK);
    assign o_stat.step_pos = step_pos;
    assign o_stat.div_done = div_done;
    assign o_stat.rem_zero = (div_rem == '0);
    assign o_stat.out_free = !r_valid || i_ready;

    assign o_valid      = r_valid;
    assign o_tempo      = r_out_tempo;
    assign o_tick_rate  = r_out_rate;
    assign o_ramp_flags = r_out_flags;
    assign o_ticks_left = r_out_cnt;

endmodule

FILE: rtl/trs_ctrl.sv
// Controller state machine: sequences fetch, modulo check, tempo step, rate divide and commit.
module trs_ctrl
    import trs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_stat i_stat,
    output logic  o_ready,
    output t_cmd  o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_FETCH     = 9'b000000010,
        S_DECIDE    = 9'b000000100,
        S_MOD_WAIT  = 9'b000001000,
        S_STEP      = 9'b000010000,
        S_MUL       = 9'b000100000,
        S_RATE_ST   = 9'b001000000,
        S_RATE_WAIT = 9'b010000000,
        S_DONE      = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    priority if (i_stat.in_oor) begin
                        n_state = S_DONE;
                    end else if (i_stat.in_tick) begin
                        n_state = S_FETCH;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_stat.step_pos) begin
                    o_cmd.mod_start = 1'b1;
                    n_state         = S_MOD_WAIT;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_MOD_WAIT: begin
                // counter not a multiple of the step: keep tempo and rate
                if (i_stat.div_done) begin
                    n_state = i_stat.rem_zero ? S_STEP : S_DONE;
                end
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_RATE_ST;
            end
            S_RATE_ST: begin
                o_cmd.rate_start = 1'b1;
                n_state          = S_RATE_WAIT;
            end
            S_RATE_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.rate_latch = 1'b1;
                    n_state          = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/trs_checker.sv
// Port-level checker for the tempo ramp stepper, bound to the top level.
module trs_checker
    import trs_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_cfg_we,
    input logic [FR_W-1:0]          i_cfg_data,
    input logic                     i_valid,
    input logic                     o_ready,
    input logic                     i_op,
    input logic [1:0]               i_score_index,
    input logic [3:0]               i_seq_index,
    input logic [TEMPO_W-1:0]       i_load_tempo,
    input logic [TEMPO_W-1:0]       i_load_target,
    input logic signed [STEP_W-1:0] i_load_step,
    input logic signed [CNT_W-1:0]  i_load_ticks,
    input logic [RES_W-1:0]         i_load_resolution,
    input logic [FLAG_W-1:0]        i_load_flags,
    input logic                     o_valid,
    input logic                     i_ready,
    input logic [TEMPO_W-1:0]       o_tempo,
    input logic [RATE_W-1:0]        o_tick_rate,
    input logic [FLAG_W-1:0]        o_ramp_flags,
    input logic signed [CNT_W-1:0]  o_ticks_left
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_tempo) && $stable(o_tick_rate)
            && $stable(o_ramp_flags) && $stable(o_ticks_left))
        else $error("result word changed while stalled");

    // one word in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready && !$rose(o_valid))
        else $error("input ready or result right after accept");

    // a fresh result appears as the block returns to idle
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> o_ready)
        else $error("result shown while still busy");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("reset did not clear result and return to idle");

endmodule

bind tempo_ramp_stepper_top trs_checker u_trs_checker (.*);

FILE: tb/testbench.sv
// Self-checking testbench for the tempo ramp stepper: random and directed loads and ticks.
`timescale 1ns / 100ps

module testbench;
    import trs_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASE_WORDS  = 260;
    localparam int REPORT_LIMIT = 10;
    localparam int SETTLE       = 100;

    typedef struct {
        logic                     op;
        logic [1:0]               score;
        logic [3:0]               seq;
        logic [TEMPO_W-1:0]       tempo;
        logic [TEMPO_W-1:0]       target;
        logic signed [STEP_W-1:0] step;
        logic [CNT_W-1:0]         ticks;
        logic [RES_W-1:0]         res;
        logic [FLAG_W-1:0]        flags;
        bit                       drain_first;
    } t_word;

    typedef struct packed {
        logic [TEMPO_W-1:0] tempo;
        logic [RATE_W-1:0]  rate;
        logic [FLAG_W-1:0]  flags;
        logic [CNT_W-1:0]   ticks;
    } t_status;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [FR_W-1:0]          i_cfg_data = '0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic                     i_op = OP_LOAD;
    logic [1:0]               i_score_index = '0;
    logic [3:0]               i_seq_index = '0;
    logic [TEMPO_W-1:0]       i_load_tempo = '0;
    logic [TEMPO_W-1:0]       i_load_target = '0;
    logic signed [STEP_W-1:0] i_load_step = '0;
    logic signed [CNT_W-1:0]  i_load_ticks = '0;
    logic [RES_W-1:0]         i_load_resolution = '0;
    logic [FLAG_W-1:0]        i_load_flags = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic [TEMPO_W-1:0]       o_tempo;
    logic [RATE_W-1:0]        o_tick_rate;
    logic [FLAG_W-1:0]        o_ramp_flags;
    logic signed [CNT_W-1:0]  o_ticks_left;

    tempo_ramp_stepper_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_op              (i_op),
        .i_score_index     (i_score_index),
        .i_seq_index       (i_seq_index),
        .i_load_tempo      (i_load_tempo),
        .i_load_target     (i_load_target),
        .i_load_step       (i_load_step),
        .i_load_ticks      (i_load_ticks),
        .i_load_resolution (i_load_resolution),
        .i_load_flags      (i_load_flags),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_tempo           (o_tempo),
        .o_tick_rate       (o_tick_rate),
        .o_ramp_flags      (o_ramp_flags),
        .o_ticks_left      (o_ticks_left)
    );

    always #5 i_clk = ~i_clk;

    // Predictor copy of the sequence table and the frame rate register.
    logic [TEMPO_W-1:0]       sq_tempo  [ENTRY_COUNT];
    logic [TEMPO_W-1:0]       sq_target [ENTRY_COUNT];
    logic signed [STEP_W-1:0] sq_step   [ENTRY_COUNT];
    logic [CNT_W-1:0]         sq_cnt    [ENTRY_COUNT];
    logic [RES_W-1:0]         sq_res    [ENTRY_COUNT];
    logic [RATE_W-1:0]        sq_rate   [ENTRY_COUNT];
    logic [FLAG_W-1:0]        sq_flags  [ENTRY_COUNT] = '{default: '0};
    logic [FR_W-1:0]          frame_rate_m = FRAME_RATE_RST;

    bit    loaded [ENTRY_COUNT] = '{default: 1'b0};
    t_word word_q [$];
    t_status status_q [$];
    t_word cur_word;
    bit    word_taken = 1'b0;
    bit    steady = 1'b0;
    int    errors = 0;
    int    cycle_count = 0;
    int    n_loads = 0;
    int    n_ticks = 0;
    int    n_ramp_ends = 0;
    int    n_settings = 1;

    function automatic logic [RATE_W-1:0] tick_rate_of(logic [RES_W-1:0] res,
                                                       logic [TEMPO_W-1:0] tmp);
        longint unsigned num;
        longint unsigned den;
        longint unsigned r;
        num = longint'(res) * longint'(tmp) * 64'd10;
        den = ((frame_rate_m == 0) ? 64'd1 : longint'(frame_rate_m)) * 64'd60;
        r = num / den;
        if (r == 0)
            r = 1;
        return r[RATE_W-1:0];
    endfunction

    // Apply one word to the predicted table and return the entry's new status.
    function automatic t_status step_sequence(t_word w);
        int unsigned e;
        int tmp;
        int tgt;
        int stp;
        int cnt;
        t_status s;
        e = {26'd0, w.score, w.seq};
        if (w.op == OP_LOAD) begin
            sq_tempo[e]  = w.tempo;
            sq_target[e] = w.target;
            sq_step[e]   = w.step;
            sq_cnt[e]    = w.ticks;
            sq_res[e]    = w.res;
            sq_flags[e]  = w.flags;
            sq_rate[e]   = tick_rate_of(w.res, w.tempo);
            n_loads++;
        end else begin
            n_ticks++;
            sq_cnt[e] = sq_cnt[e] - 32'd1;
            cnt = sq_cnt[e];
            tmp = int'(sq_tempo[e]);
            tgt = int'(sq_target[e]);
            stp = int'(sq_step[e]);
            if (stp > 0) begin
                // one unit toward the target on every step-th count
                if (cnt % stp == 0) begin
                    if (tmp > tgt)
                        tmp--;
                    else if (tmp < tgt)
                        tmp++;
                    sq_rate[e] = tick_rate_of(sq_res[e], tmp[TEMPO_W-1:0]);
                end
            end else begin
                if (tmp > tgt) begin
                    tmp += stp;
                    if (tmp < tgt)
                        tmp = tgt;
                end else if (tmp < tgt) begin
                    tmp -= stp;
                    if (tmp > tgt)
                        tmp = tgt;
                end
                sq_rate[e] = tick_rate_of(sq_res[e], tmp[TEMPO_W-1:0]);
            end
            sq_tempo[e] = tmp[TEMPO_W-1:0];
            if (cnt == 0 || tmp == tgt) begin
                if (sq_flags[e] != 0)
                    n_ramp_ends++;
                sq_flags[e] = '0;
            end
        end
        s.tempo = sq_tempo[e];
        s.rate  = sq_rate[e];
        s.flags = sq_flags[e];
        s.ticks = sq_cnt[e];
        return s;
    endfunction

    task automatic push_load(int e, int tmp, int tgt, logic [STEP_W-1:0] stp,
                             logic [CNT_W-1:0] tks, int res, int flg);
        t_word w;
        w.op          = OP_LOAD;
        w.score       = 2'(e / SEQ_COUNT);
        w.seq         = 4'(e % SEQ_COUNT);
        w.tempo       = TEMPO_W'(tmp);
        w.target      = TEMPO_W'(tgt);
        w.step        = stp;
        w.ticks       = tks;
        w.res         = RES_W'(res);
        w.flags       = FLAG_W'(flg);
        w.drain_first = ($urandom_range(0, 99) < 2);
        loaded[e] = 1'b1;
        word_q.push_back(w);
    endtask

    task automatic push_tick(int e, int n);
        t_word w;
        w = '{default: '0};
        w.op    = OP_TICK;
        w.score = 2'(e / SEQ_COUNT);
        w.seq   = 4'(e % SEQ_COUNT);
        // random don't-care payload so the load fields toggle under ticks too
        for (int i = 0; i < n; i++) begin
            w.tempo       = TEMPO_W'($urandom);
            w.target      = TEMPO_W'($urandom);
            w.step        = STEP_W'($urandom);
            w.ticks       = $urandom;
            w.res         = RES_W'($urandom);
            w.flags       = FLAG_W'($urandom);
            w.drain_first = ($urandom_range(0, 99) < 2);
            word_q.push_back(w);
        end
    endtask

    task automatic push_random_load(int e);
        int tmp;
        int tgt;
        int res;
        logic [STEP_W-1:0] stp;
        logic [CNT_W-1:0] tks;
        case ($urandom_range(0, 9))
            0: begin
                tmp = $urandom_range(0, 1) ? 32767 : 0;
                tgt = $urandom_range(0, 1) ? 32767 : 0;
            end
            1, 2, 3, 4: begin
                tmp = $urandom_range(0, 32767);
                tgt = tmp + $urandom_range(0, 24) - 12;
                if (tgt < 0)
                    tgt = 0;
                if (tgt > 32767)
                    tgt = 32767;
            end
            default: begin
                tmp = $urandom_range(0, 32767);
                tgt = $urandom_range(0, 32767);
            end
        endcase
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5: stp = STEP_W'($urandom_range(1, 4));
            6, 7, 8, 9, 10:   stp = STEP_W'(-$urandom_range(0, 10));
            11, 12, 13, 14, 15: stp = STEP_W'($urandom);
            default: begin
                case ($urandom_range(0, 3))
                    0: stp = 16'h8000;
                    1: stp = 16'h7fff;
                    2: stp = 16'h0000;
                    default: stp = 16'h0001;
                endcase
            end
        endcase
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: tks = $urandom_range(0, 8);
            8, 9, 10, 11:           tks = $urandom_range(0, 40);
            12, 13, 14, 15, 16:     tks = $urandom;
            default:                tks = 32'h8000_0003 - $urandom_range(0, 6);
        endcase
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4:  res = $urandom_range(0, 100);
            5, 6, 7:        res = $urandom_range(0, 1) ? 32767 : 0;
            default:        res = $urandom_range(0, 32767);
        endcase
        push_load(e, tmp, tgt, stp, tks, res, $urandom_range(0, 3));
    endtask

    // Mostly load-then-tick runs on one entry, with jumps to other entries.
    task automatic queue_random(int n);
        int e;
        e = $urandom_range(0, ENTRY_COUNT - 1);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) >= 60)
                e = $urandom_range(0, ENTRY_COUNT - 1);
            if (!loaded[e] || $urandom_range(0, 99) < 15)
                push_random_load(e);
            else
                push_tick(e, 1);
        end
    endtask

    task automatic queue_directed();
        // floor of the rate, unit steps up to a counter of zero
        push_load(0, 0, 32767, 16'sd1, 32'd3, 32767, 3);
        push_tick(0, 3);
        // largest tempo, most negative step, counter wraps from its minimum
        push_load(63, 32767, 0, 16'sh8000, 32'h8000_0000, 32767, 3);
        push_tick(63, 1);
        // zero step holds the tempo, zero resolution, counter from all ones
        push_load(17, 100, 110, 16'sd0, 32'hffff_ffff, 0, 2);
        push_tick(17, 1);
        // negative step moving down; counter crosses zero
        push_load(34, 500, 400, -16'sd7, 32'd1, 480, 1);
        push_tick(34, 2);
        // tempo already at target, counter from its maximum
        push_load(48, 120, 120, 16'sd5, 32'h7fff_ffff, 96, 3);
        push_tick(48, 1);
        push_load(5, 200, 100, 16'sd3, 32'd10, 192, 3);
        push_tick(5, 3);
        // largest positive step with a negative multiple of it
        push_load(6, 10, 0, 16'sh7fff, -32'sd32766, 1000, 3);
        push_tick(6, 1);
        // upward move overshoots past the field width, clamp at target
        push_load(7, 0, 32767, 16'sh8000, 32'd5, 32767, 1);
        push_tick(7, 1);
    endtask

    task automatic wait_idle();
        while (word_q.size() != 0 || i_valid || status_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_frame_rate(logic [FR_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Driver: present the next word at the falling edge, hold it until taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_ready <= 1'b0;
        end else begin
            i_ready <= steady || ($urandom_range(0, 99) >= 30);
            if (!i_valid || word_taken) begin
                word_taken = 1'b0;
                if (word_q.size() != 0 && (steady || $urandom_range(0, 99) >= 30) &&
                    !(word_q[0].drain_first && status_q.size() != 0)) begin
                    cur_word = word_q.pop_front();
                    i_valid           <= 1'b1;
                    i_op              <= cur_word.op;
                    i_score_index     <= cur_word.score;
                    i_seq_index       <= cur_word.seq;
                    i_load_tempo      <= cur_word.tempo;
                    i_load_target     <= cur_word.target;
                    i_load_step       <= cur_word.step;
                    i_load_ticks      <= cur_word.ticks;
                    i_load_resolution <= cur_word.res;
                    i_load_flags      <= cur_word.flags;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Track register writes and accepted words; predict each result.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                frame_rate_m = i_cfg_data;
            if (i_valid && o_ready) begin
                status_q.push_back(step_sequence(cur_word));
                word_taken = 1'b1;
            end
        end
    end

    // Monitor: check every taken result against the oldest prediction.
    always @(posedge i_clk) begin
        t_status want;
        t_status got;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_tempo, o_tick_rate, o_ramp_flags, o_ticks_left};
            if (status_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: result with nothing pending: %s%0d %s%0d %s%0d %s%0d",
                             $realtime, "tempo=", got.tempo, "rate=", got.rate,
                             "flags=", got.flags, "ticks=", $signed(got.ticks));
            end else begin
                want = status_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= REPORT_LIMIT) begin
                        $display("%0t: mismatch exp tempo=%0d rate=%0d flags=%0d ticks=%0d",
                                 $realtime, want.tempo, want.rate, want.flags,
                                 $signed(want.ticks));
                        $display("%0t:          got tempo=%0d rate=%0d flags=%0d ticks=%0d",
                                 $realtime, got.tempo, got.rate, got.flags,
                                 $signed(got.ticks));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $realtime, status_q.size());
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin
        logic [FR_W-1:0] rates [5];
        rates = '{8'd255, 8'd1, 8'd0, 8'd60, 8'd60};
        rates[3] = FR_W'($urandom_range(2, 254));
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_directed();
        wait_idle();
        for (int ph = 0; ph < 5; ph++) begin
            write_frame_rate(rates[ph]);
            n_settings++;
            steady = (ph == 2);
            queue_random(PHASE_WORDS);
            wait_idle();
        end
        steady = 1'b0;

        repeat (SETTLE) @(posedge i_clk);
        if (status_q.size() != 0) begin
            errors += status_q.size();
            $display("%0d predicted results never arrived", status_q.size());
        end
        $display("covered %0d loads and %0d ticks across %0d frame rate settings",
                 n_loads, n_ticks, n_settings);
        $display("%0d ramps ended on a tick, %0d failures", n_ramp_ends, errors);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
